// File: rtl/dlcf_pkg.sv
// Package for the draw list cull filter: sizes, codes and the queued operation type.
package dlcf_pkg;

    localparam int HIT_DEPTH   = 1024;
    localparam int STACK_DEPTH = 32;
    localparam int INDEX_BITS  = 16;
    localparam int Q_DEPTH     = 4;

    localparam int HIT_AW     = (HIT_DEPTH > 1) ? $clog2(HIT_DEPTH) : 1;
    localparam int HIT_CB     = $clog2(HIT_DEPTH + 1);
    localparam int STK_AW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int STK_LB     = $clog2(STACK_DEPTH + 1);
    localparam int PEND_BITS  = INDEX_BITS + 1;
    localparam int ENTRY_BITS = INDEX_BITS + 2;
    localparam int Q_AW       = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CB       = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_CMD   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [2:0] CAT_ATTR    = 3'd0;
    localparam logic [2:0] CAT_XFORM   = 3'd1;
    localparam logic [2:0] CAT_DRAW    = 3'd2;
    localparam logic [2:0] CAT_SAVE    = 3'd3;
    localparam logic [2:0] CAT_RESTORE = 3'd4;

    typedef enum logic [1:0] {
        K_LOAD,
        K_CMD,
        K_CLEAR,
        K_NOP
    } t_kind;

    typedef enum logic [2:0] {
        C_ATTR,
        C_XFORM,
        C_DRAW,
        C_SAVE,
        C_RESTORE,
        C_OTHER
    } t_cls;

    typedef struct packed {
        t_kind                  kind;
        t_cls                   cls;
        logic [INDEX_BITS-1:0]  hit_index;
        logic [INDEX_BITS-1:0]  restore_at;
    } t_op;

    typedef enum logic [1:0] {
        S_RUN,
        S_LOAD,
        S_DRAIN
    } t_state;

endpackage

// File: rtl/dlcf_in_if.sv
// Input channel of the draw list cull filter: valid, ready and one input beat.
interface dlcf_in_if;
    import dlcf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [1:0]             action;
    logic [INDEX_BITS-1:0]  hit_index;
    logic [2:0]             category;
    logic [INDEX_BITS-1:0]  restore_at;

    modport source (output valid, action, hit_index, category, restore_at, input ready);
    modport sink   (input valid, action, hit_index, category, restore_at, output ready);
endinterface

// File: rtl/dlcf_out_if.sv
// Result channel of the draw list cull filter: valid, ready and one result beat.
interface dlcf_out_if;
    import dlcf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [INDEX_BITS-1:0]  kept_index;
    logic                   last_of_run;
    logic                   done_res;
    logic                   overflow;

    modport source (output valid, kept_index, last_of_run, done_res, overflow, input ready);
    modport sink   (input valid, kept_index, last_of_run, done_res, overflow, output ready);
endinterface

// File: rtl/dlcf_front.sv
// Front stage: accepts input beats, decodes action and category, registers the operation.
module dlcf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dlcf_in_if.sink        i_cmd,
    output logic           o_push_valid,
    output dlcf_pkg::t_op  o_push_op,
    input  logic           i_push_ready
);
    import dlcf_pkg::*;

    logic r_valid;
    t_op  r_op;
    t_op  n_op;

    assign i_cmd.ready  = !r_valid || i_push_ready;
    assign o_push_valid = r_valid;
    assign o_push_op    = r_op;

    always_comb begin
        n_op.hit_index  = i_cmd.hit_index;
        n_op.restore_at = i_cmd.restore_at;
        case (i_cmd.action)
            ACT_LOAD:  n_op.kind = K_LOAD;
            ACT_CMD:   n_op.kind = K_CMD;
            ACT_CLEAR: n_op.kind = K_CLEAR;
            default:   n_op.kind = K_NOP;
        endcase
        case (i_cmd.category)
            CAT_ATTR:    n_op.cls = C_ATTR;
            CAT_XFORM:   n_op.cls = C_XFORM;
            CAT_DRAW:    n_op.cls = C_DRAW;
            CAT_SAVE:    n_op.cls = C_SAVE;
            CAT_RESTORE: n_op.cls = C_RESTORE;
            default:     n_op.cls = C_OTHER;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_op <= n_op;
        end
    end
endmodule

// File: rtl/dlcf_queue.sv
// Short operation queue that decouples the front stage from the back stage.
module dlcf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  dlcf_pkg::t_op  i_push_op,
    output logic           o_push_ready,
    output logic           o_head_valid,
    output dlcf_pkg::t_op  o_head_op,
    input  logic           i_pop
);
    import dlcf_pkg::*;

    t_op              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr;
    logic [Q_CB-1:0]  r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != Q_CB'(Q_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head_op    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_head_valid;

    function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
        logic [Q_AW-1:0] r;
        if (p == Q_AW'(Q_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_op;
        end
    end
endmodule

// File: rtl/dlcf_back.sv
// Back stage: hit memory, save stack, culling decisions, stack drain and result register.
module dlcf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  dlcf_pkg::t_op  i_head_op,
    output logic           o_pop,
    dlcf_out_if.source     o_res
);
    import dlcf_pkg::*;

    localparam logic [PEND_BITS-1:0] PEND_NONE = '1;

    // Hit memory and save stack.
    logic [INDEX_BITS-1:0]  r_hit_mem [HIT_DEPTH];
    logic [INDEX_BITS-1:0]  r_rd_data;
    logic [ENTRY_BITS-1:0]  r_stack [STACK_DEPTH];

    t_state                 r_state;
    t_state                 n_state;
    logic [HIT_CB-1:0]      r_count, n_count;
    logic [HIT_CB-1:0]      r_ptr, n_ptr;
    logic [INDEX_BITS-1:0]  r_nr, n_nr;
    logic [PEND_BITS-1:0]   r_pend, n_pend;
    logic [STK_LB-1:0]      r_level, n_level;
    logic [INDEX_BITS-1:0]  r_ctr, n_ctr;
    logic                   r_fin, n_fin;
    logic                   r_err, n_err;
    logic                   r_held_valid, n_held_valid;
    logic [INDEX_BITS-1:0]  r_held_idx, n_held_idx;

    logic                   r_out_valid;
    logic [INDEX_BITS-1:0]  r_out_idx;
    logic                   r_out_last;
    logic                   r_out_done;
    logic                   r_out_ovf;

    logic                   out_we;
    logic [INDEX_BITS-1:0]  out_idx;
    logic                   out_last;
    logic                   out_done;
    logic                   mem_we;
    logic                   rd_en;
    logic                   stk_we;
    logic [ENTRY_BITS-1:0]  stk_wd;

    logic                   out_free;
    logic                   cmd_live;
    logic                   no_hits;
    logic                   first_hit;
    logic                   beyond;
    logic                   more_hits;
    logic                   fetch_go;
    logic                   drain_go;
    logic                   exec;
    logic                   needed;
    logic                   stk_empty;
    logic [STK_LB-1:0]      level_m1;
    logic [ENTRY_BITS-1:0]  top;
    logic                   emit;

    assign out_free  = !r_out_valid || o_res.ready;
    assign cmd_live  = i_head_valid && (i_head_op.kind == K_CMD) && !r_fin;
    assign no_hits   = (r_ptr == '0) && (r_count == '0);
    assign first_hit = (r_ptr == '0) && (r_count != '0);
    assign beyond    = (r_ptr != '0) && (r_ctr > r_nr);
    assign more_hits = (r_ptr < r_count);
    assign fetch_go  = first_hit || (beyond && more_hits);
    assign drain_go  = beyond && !more_hits;
    assign exec      = (r_ptr != '0) && !beyond;
    assign needed    = ({1'b0, r_nr} < r_pend);
    assign stk_empty = (r_level == '0);
    assign level_m1  = r_level - 1'b1;
    assign top       = r_stack[level_m1[STK_AW-1:0]];

    always_comb begin
        case (i_head_op.cls)
            C_ATTR:    emit = 1'b1;
            C_XFORM:   emit = needed;
            C_DRAW:    emit = (r_ctr == r_nr);
            C_SAVE:    emit = needed;
            C_RESTORE: emit = !stk_empty && top[ENTRY_BITS-1];
            default:   emit = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RUN: begin
                if (cmd_live && !no_hits) begin
                    if (fetch_go) begin
                        n_state = S_LOAD;
                    end else if (drain_go) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_LOAD: n_state = S_RUN;
            S_DRAIN: begin
                if (stk_empty && out_free) begin
                    n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    // Datapath and control outputs.
    always_comb begin
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_nr         = r_nr;
        n_pend       = r_pend;
        n_level      = r_level;
        n_ctr        = r_ctr;
        n_fin        = r_fin;
        n_err        = r_err;
        n_held_valid = r_held_valid;
        n_held_idx   = r_held_idx;
        o_pop        = 1'b0;
        mem_we       = 1'b0;
        rd_en        = 1'b0;
        stk_we       = 1'b0;
        stk_wd       = {needed, r_pend};
        out_we       = 1'b0;
        out_idx      = r_ctr;
        out_last     = 1'b1;
        out_done     = 1'b0;
        case (r_state)
            S_RUN: begin
                if (i_head_valid) begin
                    case (i_head_op.kind)
                        K_LOAD: begin
                            o_pop = 1'b1;
                            if (r_count < HIT_CB'(HIT_DEPTH)) begin
                                mem_we  = 1'b1;
                                n_count = r_count + 1'b1;
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                        K_CLEAR: begin
                            o_pop   = 1'b1;
                            n_count = '0;
                            n_ptr   = '0;
                            n_nr    = '0;
                            n_pend  = PEND_NONE;
                            n_level = '0;
                            n_ctr   = '0;
                            n_fin   = 1'b0;
                            n_err   = 1'b0;
                        end
                        K_CMD: begin
                            if (r_fin) begin
                                o_pop = 1'b1;
                            end else if (no_hits) begin
                                o_pop = 1'b1;
                                n_fin = 1'b1;
                            end else if (fetch_go) begin
                                rd_en = 1'b1;
                            end else if (exec && (!emit || out_free)) begin
                                o_pop = 1'b1;
                                n_ctr = r_ctr + 1'b1;
                                case (i_head_op.cls)
                                    C_SAVE: begin
                                        if (r_level < STK_LB'(STACK_DEPTH)) begin
                                            stk_we  = 1'b1;
                                            n_level = r_level + 1'b1;
                                        end else begin
                                            n_err = 1'b1;
                                        end
                                        n_pend = {1'b0, i_head_op.restore_at};
                                    end
                                    C_RESTORE: begin
                                        if (stk_empty) begin
                                            n_pend = PEND_NONE;
                                        end else begin
                                            n_level = level_m1;
                                            n_pend  = top[PEND_BITS-1:0];
                                        end
                                    end
                                    default: begin
                                    end
                                endcase
                                out_we = emit;
                            end
                        end
                        default: o_pop = 1'b1;
                    endcase
                end
            end
            S_LOAD: begin
                n_nr  = r_rd_data;
                n_ptr = r_ptr + 1'b1;
            end
            S_DRAIN: begin
                out_done = 1'b1;
                if (!stk_empty) begin
                    if (!top[ENTRY_BITS-1]) begin
                        n_level = level_m1;
                        n_pend  = top[PEND_BITS-1:0];
                    end else if (!r_held_valid || out_free) begin
                        // A newer needed restore shows the held one is not the last.
                        out_we       = r_held_valid;
                        out_idx      = r_held_idx;
                        out_last     = 1'b0;
                        n_held_valid = 1'b1;
                        n_held_idx   = r_pend[INDEX_BITS-1:0];
                        n_level      = level_m1;
                        n_pend       = top[PEND_BITS-1:0];
                    end
                end else if (out_free) begin
                    // Final beat of the drain, or the marker when nothing was needed.
                    out_we       = 1'b1;
                    out_idx      = r_held_valid ? r_held_idx : '0;
                    n_held_valid = 1'b0;
                    n_pend       = PEND_NONE;
                    n_fin        = 1'b1;
                    o_pop        = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_RUN;
            r_count      <= '0;
            r_ptr        <= '0;
            r_nr         <= '0;
            r_pend       <= PEND_NONE;
            r_level      <= '0;
            r_ctr        <= '0;
            r_fin        <= 1'b0;
            r_err        <= 1'b0;
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_ptr        <= n_ptr;
            r_nr         <= n_nr;
            r_pend       <= n_pend;
            r_level      <= n_level;
            r_ctr        <= n_ctr;
            r_fin        <= n_fin;
            r_err        <= n_err;
            r_held_valid <= n_held_valid;
            if (out_we) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_held_idx <= n_held_idx;
        if (out_we) begin
            r_out_idx  <= out_idx;
            r_out_last <= out_last;
            r_out_done <= out_done;
            r_out_ovf  <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hit_mem[r_count[HIT_AW-1:0]] <= i_head_op.hit_index;
        end
        if (rd_en) begin
            r_rd_data <= r_hit_mem[r_ptr[HIT_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[r_level[STK_AW-1:0]] <= stk_wd;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.kept_index  = r_out_idx;
    assign o_res.last_of_run = r_out_last;
    assign o_res.done_res    = r_out_done;
    assign o_res.overflow    = r_out_ovf;
endmodule

// File: rtl/draw_list_cull_filter_top.sv
// Beats are registered by the front stage and the queue before the back stage; a kept
// index is registered at the result port. Throughput: one beat per cycle in order unless
// hit reads, drains or a held result port stall it. The first command of a pass and each
// skipped hit wait on a registered hit memory read; the drain pops stacked saves singly
// before the final beat. Reset is synchronous and active low; it empties the queue and
// resets all culling state. Hit memory and save stack are not cleared and need no pass.
module draw_list_cull_filter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dlcf_in_if.sink     i_cmd,
    dlcf_out_if.source  o_res
);
    import dlcf_pkg::*;

    // Front to queue: one decoded operation per beat.
    logic  push_valid;
    logic  push_ready;
    t_op   push_op;

    // Queue to back: the head operation, popped once the back stage has carried it out.
    logic  head_valid;
    t_op   head_op;
    logic  pop;

    // The front stage decodes action and category so the back stage switches on enums only.
    dlcf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .o_push_valid (push_valid),
        .o_push_op    (push_op),
        .i_push_ready (push_ready)
    );

    // The queue lets the front keep accepting beats while the back stage skips hits
    // or drains the save stack.
    dlcf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_op    (push_op),
        .o_push_ready (push_ready),
        .o_head_valid (head_valid),
        .o_head_op    (head_op),
        .i_pop        (pop)
    );

    // The back stage holds the hit memory, the save stack and the result register.
    dlcf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_op    (head_op),
        .o_pop        (pop),
        .o_res        (o_res)
    );
endmodule

// File: tb/tb.sv
// Self-checking testbench for the draw list cull filter: directed, overflow and random lists.
module tb;
    import dlcf_pkg::*;

    // Run limits.
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_KEPT    = 32;
    localparam int STEADY_BEATS = 80;
    localparam int RANDOM_BEATS = 240;
    localparam int TAIL_CYCLES = 40;

    // One input beat as the block sees it.
    typedef struct packed {
        logic [1:0]            action;
        logic [INDEX_BITS-1:0] hit_index;
        logic [2:0]            category;
        logic [INDEX_BITS-1:0] restore_at;
    } t_cmd_beat;

    // One result beat as the block shows it.
    typedef struct packed {
        logic [INDEX_BITS-1:0] kept_index;
        logic                  last_of_run;
        logic                  done_res;
        logic                  overflow;
    } t_kept_beat;

    // The scoreboard keeps its own copy of the culling state. Every accepted input beat is
    // run through that copy and the kept indices it causes are queued; every accepted result
    // beat is compared against the head of that queue.
    class cull_checker;
        logic [INDEX_BITS-1:0] hits [HIT_DEPTH];
        logic [ENTRY_BITS-1:0] saves [STACK_DEPTH];
        int unsigned           hit_cnt;
        int unsigned           rd_ptr;
        int unsigned           level;
        logic [INDEX_BITS-1:0] next_hit;
        logic [INDEX_BITS-1:0] cmd_idx;
        logic [PEND_BITS-1:0]  pend;
        bit                    finished;
        bit                    err_seen;
        t_kept_beat            kept_expected [$];
        t_kept_beat            run [$];
        int                    errors;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            hit_cnt  = 0;
            rd_ptr   = 0;
            level    = 0;
            next_hit = '0;
            cmd_idx  = '0;
            pend     = '1;
            finished = 1'b0;
            err_seen = 1'b0;
        endfunction

        function void keep(logic [INDEX_BITS-1:0] idx, bit drained);
            t_kept_beat b;
            b.kept_index  = idx;
            b.last_of_run = 1'b0;
            b.done_res    = drained;
            b.overflow    = err_seen;
            run.insert(run.size(), b);
        endfunction

        function void note_beat(t_cmd_beat c);
            logic [INDEX_BITS-1:0] idx;
            logic [ENTRY_BITS-1:0] e;
            bit                    needed;
            int                    n;
            run.delete();
            if (c.action == ACT_LOAD) begin
                if (hit_cnt < HIT_DEPTH) begin
                    hits[hit_cnt] = c.hit_index;
                    hit_cnt++;
                end else begin
                    err_seen = 1'b1;
                end
                return;
            end
            if (c.action == ACT_CLEAR) begin
                clear_state();
                return;
            end
            if (c.action != ACT_CMD || finished) return;

            idx = cmd_idx;
            if (rd_ptr == 0) begin
                if (hit_cnt == 0) begin
                    finished = 1'b1;
                    return;
                end
                next_hit = hits[0];
                rd_ptr   = 1;
            end
            // Skip hits that lie behind this command; past the last hit the stack drains.
            while (idx > next_hit && !finished) begin
                if (rd_ptr < hit_cnt) begin
                    next_hit = hits[rd_ptr];
                    rd_ptr++;
                end else begin
                    n = 0;
                    while (level > 0) begin
                        level--;
                        e = saves[level];
                        if (e[ENTRY_BITS-1] && n < MAX_KEPT) begin
                            keep(pend[INDEX_BITS-1:0], 1'b1);
                            n++;
                        end
                        pend = e[PEND_BITS-1:0];
                    end
                    pend     = '1;
                    finished = 1'b1;
                    if (n == 0) keep('0, 1'b1);
                end
            end
            if (!finished) begin
                cmd_idx++;
                case (c.category)
                    CAT_ATTR: begin
                        keep(idx, 1'b0);
                    end
                    CAT_XFORM: begin
                        if ({1'b0, next_hit} < pend) keep(idx, 1'b0);
                    end
                    CAT_DRAW: begin
                        if (idx == next_hit) keep(idx, 1'b0);
                    end
                    CAT_SAVE: begin
                        needed = ({1'b0, next_hit} < pend);
                        if (level < STACK_DEPTH) begin
                            saves[level] = {needed, pend};
                            level++;
                        end else begin
                            err_seen = 1'b1;
                        end
                        pend = {1'b0, c.restore_at};
                        if (needed) keep(idx, 1'b0);
                    end
                    CAT_RESTORE: begin
                        if (level == 0) begin
                            pend = '1;
                        end else begin
                            level--;
                            pend = saves[level][PEND_BITS-1:0];
                            if (saves[level][ENTRY_BITS-1]) keep(idx, 1'b0);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
            foreach (run[k]) kept_expected.insert(kept_expected.size(), run[k]);
        endfunction

        function void check_kept(t_kept_beat got);
            t_kept_beat want;
            if (kept_expected.size() == 0) begin
                $display("%0t: result beat with nothing expected: index %0d last %0b",
                         $time, got.kept_index, got.last_of_run);
                $display("%0t:   done %0b ovf %0b", $time, got.done_res, got.overflow);
                errors++;
                return;
            end
            want = kept_expected.pop_front();
            if (got.kept_index !== want.kept_index) begin
                $display("%0t: kept_index expected %0d actual %0d",
                         $time, want.kept_index, got.kept_index);
                errors++;
            end
            if (got.last_of_run !== want.last_of_run) begin
                $display("%0t: last_of_run expected %0b actual %0b (index %0d)",
                         $time, want.last_of_run, got.last_of_run, want.kept_index);
                errors++;
            end
            if (got.done_res !== want.done_res) begin
                $display("%0t: done_res expected %0b actual %0b (index %0d)",
                         $time, want.done_res, got.done_res, want.kept_index);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $display("%0t: overflow expected %0b actual %0b (index %0d)",
                         $time, want.overflow, got.overflow, want.kept_index);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    dlcf_in_if  cmd_if ();
    dlcf_out_if res_if ();

    cull_checker board;

    // When steady is set, neither side inserts idle cycles. Each increment of hold_asks makes
    // the result side hold ready low for a long stretch so the block backs up into its input.
    bit steady = 1'b0;
    int hold_asks = 0;
    int cycle_cnt = 0;
    int beats_sent = 0;

    draw_list_cull_filter_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Watchdog: a hung block or a lost beat ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side. Outputs are sampled at the rising edge before any update of that edge, and
    // ready is changed by a nonblocking assignment after the sample, so there is no race.
    initial begin : result_sink
        int         hold_left;
        int         hold_seen;
        t_kept_beat got;
        hold_left = 0;
        hold_seen = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                got.kept_index  = res_if.kept_index;
                got.last_of_run = res_if.last_of_run;
                got.done_res    = res_if.done_res;
                got.overflow    = res_if.overflow;
                board.check_kept(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= steady || ($urandom_range(99) >= 25);
            end
        end
    end

    // Offers one input beat, with random idle cycles ahead of it, and waits until the block
    // takes it. Valid stays high into the next beat unless an idle cycle follows.
    task automatic send_beat(input logic [1:0] act, input logic [INDEX_BITS-1:0] hit,
                             input logic [2:0] cat, input logic [INDEX_BITS-1:0] rest);
        t_cmd_beat b;
        b.action     = act;
        b.hit_index  = hit;
        b.category   = cat;
        b.restore_at = rest;
        while (!steady && $urandom_range(99) < 25) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.action     <= act;
        cmd_if.hit_index  <= hit;
        cmd_if.category   <= cat;
        cmd_if.restore_at <= rest;
        do @(posedge i_clk); while (!cmd_if.ready);
        board.note_beat(b);
        beats_sent++;
    endtask

    // Unused fields of each beat carry random values so every bit toggles.
    task automatic load_hit(input logic [INDEX_BITS-1:0] hit);
        send_beat(ACT_LOAD, hit, 3'($urandom), 16'($urandom));
    endtask

    task automatic issue(input logic [2:0] cat, input logic [INDEX_BITS-1:0] rest);
        send_beat(ACT_CMD, 16'($urandom), cat, rest);
    endtask

    task automatic clear_list();
        send_beat(ACT_CLEAR, 16'($urandom), 3'($urandom), 16'($urandom));
    endtask

    // A random list: a clear, ascending hits, then a command stream with properly nested
    // save and restore pairs whose restore_at points at the matching restore. About one list
    // in five is broken: stray actions, unknown categories, random restore targets and hits.
    task automatic random_list();
        int                    n_cmds;
        int                    n_hits;
        int                    pos;
        int                    k;
        int                    r;
        int                    open_saves [$];
        logic [2:0]            cats [$];
        logic [INDEX_BITS-1:0] rests [$];
        logic [INDEX_BITS-1:0] hit_val;
        bit                    broken;
        broken = ($urandom_range(99) < 20);
        clear_list();
        n_cmds  = $urandom_range(6, 40);
        n_hits  = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
        hit_val = 16'($urandom_range(0, 3));
        for (k = 0; k < n_hits; k++) begin
            load_hit((broken && $urandom_range(3) == 0) ? 16'($urandom) : hit_val);
            hit_val = hit_val + 16'($urandom_range(1, n_cmds / 3));
        end
        for (pos = 0; pos < n_cmds; pos++) begin
            r = $urandom_range(99);
            if (r < 18 && open_saves.size() < 6) begin
                cats.insert(cats.size(), CAT_SAVE);
                rests.insert(rests.size(), 16'(n_cmds + $urandom_range(0, 9)));
                open_saves.insert(open_saves.size(), pos);
            end else if (r < 34 && open_saves.size() > 0) begin
                cats.insert(cats.size(), CAT_RESTORE);
                rests.insert(rests.size(), 16'($urandom));
                rests[open_saves[open_saves.size()-1]] = 16'(pos);
                open_saves.delete(open_saves.size()-1);
            end else begin
                cats.insert(cats.size(),
                            (r < 50) ? CAT_ATTR : (r < 70) ? CAT_XFORM : CAT_DRAW);
                rests.insert(rests.size(), 16'($urandom));
            end
        end
        for (pos = 0; pos < n_cmds; pos++) begin
            if (broken && $urandom_range(7) == 0) begin
                send_beat(2'($urandom), 16'($urandom), 3'($urandom), 16'($urandom));
            end else if (!broken && $urandom_range(24) == 0) begin
                // A hit appended while the pass is running.
                load_hit(hit_val);
                hit_val = hit_val + 16'($urandom_range(1, 8));
            end
            if (broken && $urandom_range(5) == 0) issue(3'($urandom), 16'($urandom));
            else issue(cats[pos], rests[pos]);
        end
    endtask

    initial begin : stimulus
        int k;
        int random_start;
        board = new();
        i_rst_n           = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.action     = ACT_LOAD;
        cmd_if.hit_index  = '0;
        cmd_if.category   = CAT_ATTR;
        cmd_if.restore_at = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed list. A command with no hits loaded ends the pass at once with no result,
        // and the command after it is ignored until the clear.
        issue(CAT_ATTR, 16'd0);
        issue(CAT_ATTR, 16'd0);
        clear_list();
        load_hit(16'd3);
        load_hit(16'd9);
        // Index 0 restores with an empty stack, 1 is a needed save, 2 a save that is not
        // needed, 3 a draw on a hit, 4 a restore of the unneeded save, 5 a transform culled
        // by the pending restore, 6 a restore of the needed save, 7 a kept transform.
        issue(CAT_RESTORE, 16'hFFFF);
        issue(CAT_SAVE, 16'd3);
        issue(CAT_SAVE, 16'd2);
        issue(CAT_DRAW, 16'd0);
        issue(CAT_RESTORE, 16'd0);
        issue(CAT_XFORM, 16'd0);
        issue(CAT_RESTORE, 16'd0);
        issue(CAT_XFORM, 16'd0);
        // An unknown category still takes index 8; an unknown action is dropped.
        issue(3'd7, 16'hFFFF);
        send_beat(2'd3, 16'hFFFF, 3'd7, 16'hFFFF);
        issue(CAT_DRAW, 16'd0);
        // Index 10 lies past the last hit: the empty stack drains to a single done marker.
        issue(CAT_SAVE, 16'd12);
        issue(CAT_ATTR, 16'd0);

        // Save stack overflow: two saves beyond the depth, then attributes up to and past
        // the only hit. The results are held back for a long stretch so the block fills up;
        // the last command drains a full stack into the largest burst of results.
        clear_list();
        load_hit(16'd100);
        for (k = 0; k < STACK_DEPTH + 2; k++) issue(CAT_SAVE, 16'd200);
        hold_asks++;
        for (k = STACK_DEPTH + 2; k <= 101; k++) issue(CAT_ATTR, 16'd0);

        // Random lists. The first stretch runs with no idle cycles on either side.
        random_start = beats_sent;
        steady = 1'b1;
        while (beats_sent - random_start < STEADY_BEATS) random_list();
        steady = 1'b0;
        while (beats_sent - random_start < RANDOM_BEATS) random_list();
        cmd_if.valid <= 1'b0;

        // Let every expected beat arrive, then watch a while longer for stray ones.
        while (board.kept_expected.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
